// ----- rtl/hrlf_pkg.sv -----
package hrlf_pkg;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_ERROR      = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    PH_NAME_LEAD  = 3'd0,
    PH_NAME       = 3'd1,
    PH_NAME_TRAIL = 3'd2,
    PH_VAL_LEAD   = 3'd3,
    PH_VAL        = 3'd4,
    PH_VAL_TRAIL  = 3'd5,
    PH_SKIP       = 3'd6
  } phase_t;

  localparam logic       MODE_DATA   = 1'b0;
  localparam logic       MODE_FINISH = 1'b1;
  localparam logic [3:0] KEY_LEN     = 4'd14;
  localparam logic [1:0] TERM_LAST   = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // largest accumulator value that still takes another digit
  localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  // lower-case "content-length", one character per index
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

// ----- rtl/hrlf_if.sv -----
interface hrlf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface hrlf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        header_done;
  logic        length_known;
  logic [63:0] content_length;
  logic [63:0] body_bytes;
  logic        is_body_byte;

  modport source (output valid, output status, output header_done, output length_known,
                  output content_length, output body_bytes, output is_body_byte,
                  input ready);
  modport sink   (input valid, input status, input header_done, input length_known,
                  input content_length, input body_bytes, input is_body_byte,
                  output ready);
endinterface

// ----- rtl/hrlf_in_reg.sv -----
module hrlf_in_reg import hrlf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  input  logic  item_ready,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || item_ready;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !item_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/hrlf_engine.sv -----
module hrlf_engine import hrlf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_header_done,
  output logic        out_length_known,
  output logic [63:0] out_content_length,
  output logic [63:0] out_body_bytes,
  output logic        out_is_body_byte
);

  stat_t       st_r, st_nxt;
  logic [1:0]  crlf_r, crlf_nxt;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        mism_r, mism_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        hasd_r, hasd_nxt;
  logic        lf_r, lf_nxt;
  logic        hf_r, hf_nxt;
  logic [63:0] body_r, body_nxt;
  logic        is_body;

  logic        ovalid_r;
  logic [1:0]  ostat_r;
  logic        ohd_r, olk_r, obody_r;
  logic [63:0] olen_r, ocnt_r;

  logic        advance;
  logic [7:0]  c;
  logic        ws;
  logic        after_cr;
  logic [63:0] acc_x10;

  assign item_ready = !ovalid_r || out_ready;
  assign advance    = item_valid && item_ready;
  assign c          = item.data_byte;
  assign ws         = is_ws(c);
  assign after_cr   = crlf_r[0];
  assign acc_x10    = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0};

  always_comb begin
    st_nxt    = st_r;
    crlf_nxt  = crlf_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    mism_nxt  = mism_r;
    acc_nxt   = acc_r;
    hasd_nxt  = hasd_r;
    lf_nxt    = lf_r;
    hf_nxt    = hf_r;
    body_nxt  = body_r;
    is_body   = 1'b0;

    if (st_r == ST_INCOMPLETE) begin
      if (item.mode == MODE_FINISH) begin
        if (!hf_r) begin
          st_nxt = ST_ERROR;
        end else if (!lf_r || body_r >= acc_r) begin
          st_nxt = ST_COMPLETE;
        end else begin
          st_nxt = ST_ERROR;
        end
      end else if (hf_r) begin
        is_body = 1'b1;
        if (body_r != '1) begin
          body_nxt = body_r + 64'd1;
        end
        if (lf_r && body_nxt >= acc_r) begin
          st_nxt = ST_COMPLETE;
        end
      end else begin
        if (!lf_r) begin
          if (c == CH_LF && after_cr) begin
            // line end: commit or reject the value, restart name matching
            if (phase_r == PH_VAL || phase_r == PH_VAL_TRAIL) begin
              lf_nxt = hasd_r;
            end else if (phase_r == PH_VAL_LEAD) begin
              st_nxt = ST_ERROR;
            end
            phase_nxt = PH_NAME_LEAD;
            idx_nxt   = '0;
            mism_nxt  = 1'b0;
          end else begin
            unique case (phase_r) inside
              PH_NAME_LEAD, PH_NAME, PH_NAME_TRAIL: begin
                if (c == CH_COLON) begin
                  if (!mism_r && idx_r == KEY_LEN) begin
                    phase_nxt = PH_VAL_LEAD;
                    acc_nxt   = '0;
                    hasd_nxt  = 1'b0;
                  end else begin
                    phase_nxt = PH_SKIP;
                  end
                end else if (ws) begin
                  if (phase_r == PH_NAME) begin
                    phase_nxt = PH_NAME_TRAIL;
                  end
                end else begin
                  // text after inner white space never matches the key
                  if (phase_r == PH_NAME_TRAIL || mism_r || idx_r >= KEY_LEN ||
                      fold_case(c) != key_char(idx_r)) begin
                    mism_nxt = 1'b1;
                  end else begin
                    idx_nxt = idx_r + 4'd1;
                  end
                  phase_nxt = PH_NAME;
                end
              end
              PH_VAL_LEAD, PH_VAL: begin
                if (c >= "0" && c <= "9") begin
                  if (acc_r > ACC_LIMIT || (acc_r == ACC_LIMIT && c[3:0] > 4'd5)) begin
                    st_nxt = ST_ERROR;
                  end else begin
                    acc_nxt   = acc_x10 + {60'd0, c[3:0]};
                    hasd_nxt  = 1'b1;
                    phase_nxt = PH_VAL;
                  end
                end else if (ws) begin
                  if (phase_r == PH_VAL) begin
                    phase_nxt = PH_VAL_TRAIL;
                  end
                end else begin
                  st_nxt = ST_ERROR;
                end
              end
              PH_VAL_TRAIL: begin
                if (!ws) begin
                  st_nxt = ST_ERROR;
                end
              end
              default: begin
              end
            endcase
          end
        end

        if (st_nxt == ST_INCOMPLETE) begin
          if (c == CH_CR) begin
            crlf_nxt = (crlf_r == 2'd2) ? TERM_LAST : 2'd1;
          end else if (c == CH_LF && crlf_r == 2'd1) begin
            crlf_nxt = 2'd2;
          end else if (c == CH_LF && crlf_r == TERM_LAST) begin
            crlf_nxt = 2'd0;
            hf_nxt   = 1'b1;
            if (lf_nxt && acc_nxt == '0) begin
              st_nxt = ST_COMPLETE;
            end
          end else begin
            crlf_nxt = 2'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_INCOMPLETE;
      crlf_r   <= '0;
      phase_r  <= PH_NAME_LEAD;
      idx_r    <= '0;
      mism_r   <= 1'b0;
      acc_r    <= '0;
      hasd_r   <= 1'b0;
      lf_r     <= 1'b0;
      hf_r     <= 1'b0;
      body_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r    <= st_nxt;
        crlf_r  <= crlf_nxt;
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        mism_r  <= mism_nxt;
        acc_r   <= acc_nxt;
        hasd_r  <= hasd_nxt;
        lf_r    <= lf_nxt;
        hf_r    <= hf_nxt;
        body_r  <= body_nxt;
      end
      if (advance) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // result register: payload needs no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      ostat_r <= st_nxt;
      ohd_r   <= hf_nxt;
      olk_r   <= lf_nxt;
      olen_r  <= lf_nxt ? acc_nxt : 64'd0;
      ocnt_r  <= body_nxt;
      obody_r <= is_body;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_status         = ostat_r;
  assign out_header_done    = ohd_r;
  assign out_length_known   = olk_r;
  assign out_content_length = olen_r;
  assign out_body_bytes     = ocnt_r;
  assign out_is_body_byte   = obody_r;

endmodule

// ----- rtl/http_response_length_framer_core.sv -----
// Frames an HTTP response by its content-length. Each input item is one received byte
// (mode 0) or the end of the connection (mode 1); each item yields exactly one result item
// carrying the sticky status (incomplete, complete, error), whether the header block has
// ended, the parsed length if one was found, the saturating body byte count and whether this
// byte was body. One item is taken every cycle while the result channel is not stalled; an
// accepted item is loaded into the input register, and the parser state update then moves
// its result into the result register, from which it is offered; back-pressure on the
// result channel stalls the input channel.
module http_response_length_framer_core import hrlf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hrlf_in_if.sink           in_ch,
  hrlf_out_if.source        out_ch
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_ready;

  assign in_item.mode      = in_ch.mode;
  assign in_item.data_byte = in_ch.data_byte;

  hrlf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  hrlf_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .item               (item),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_header_done    (out_ch.header_done),
    .out_length_known   (out_ch.length_known),
    .out_content_length (out_ch.content_length),
    .out_body_bytes     (out_ch.body_bytes),
    .out_is_body_byte   (out_ch.is_body_byte)
  );

  a_body_after_headers: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_body_byte |-> out_ch.header_done)
    else $error("body byte reported before the header block ended");

  a_length_zero_when_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.length_known |-> out_ch.content_length == 64'd0)
    else $error("content length nonzero without a valid length header");

  a_complete_has_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_COMPLETE && out_ch.length_known
      |-> out_ch.body_bytes >= out_ch.content_length)
    else $error("complete reported with a short body");

  a_input_stalls_with_output: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && out_ch.valid && !out_ch.ready |-> !item_ready)
    else $error("item advanced into a stalled result register");

endmodule
